>>> hdl/akcd_pkg.sv
`default_nettype none
package akcd_pkg;

    localparam int MAX_KEYS_DEF    = 5;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int KEY_BITS        = 3;
    localparam int PERIOD_BITS     = 7;
    localparam int CFG_INDEX_BITS  = 3;

    typedef logic [KEY_BITS-1:0] key_t;

    localparam key_t NO_KEY = key_t'(5);

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_COUNT    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_0  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHECK_PERIOD = 3'd6;

    localparam logic [KEY_BITS-1:0]    RESET_KEY_COUNT    = 3'd5;
    localparam logic [PERIOD_BITS-1:0] RESET_CHECK_PERIOD = 7'd100;
    localparam int RESET_THRESHOLDS [5] = '{30, 250, 360, 535, 760};

    typedef struct packed {
        logic [KEY_BITS-1:0]    key_count;
        logic [PERIOD_BITS-1:0] check_period;
    } akcd_ctrl_t;

endpackage
`default_nettype wire

>>> hdl/analog_keypad_change_detector.sv
// Resistor-ladder keypad decoder: each item on the slave stream is one ADC sample, decoded as
// the first of the configured number of ascending thresholds that it lies below (or no key);
// one sample in every check_period is judged, and a judged key that differs from the held one
// yields a result item carrying a press of the new key and a release of the old one. The block
// takes one item per clock unless m_tready stalls it; a result reaches the master stream when its
// sample has passed the input register and then the result register, around a single pass of
// compares and the sample counter, and m_tready stalls pass straight back to s_tready.
// Thresholds and counts must be written on the cfg port while the block is idle (not enforced).
`default_nettype none
module analog_keypad_change_detector
    import akcd_pkg::*;
#(
    parameter int MAX_KEYS    = MAX_KEYS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IN_BYTES    = (SAMPLE_BITS + 7) / 8,
    parameter int CFG_BITS    = (SAMPLE_BITS > PERIOD_BITS) ? SAMPLE_BITS : PERIOD_BITS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_BITS-1:0]        cfg_data,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [IN_BYTES*8-1:0]      s_tdata,   // sample
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata    // press_valid, press_key, release_valid,
                                                       // release_key
);

    akcd_ctrl_t ctrl;
    logic [MAX_KEYS-1:0][SAMPLE_BITS-1:0] thresholds;
    logic press_valid;
    key_t press_key;
    logic release_valid;
    key_t release_key;

    akcd_cfg #(
        .MAX_KEYS    (MAX_KEYS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CFG_BITS    (CFG_BITS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ctrl       (ctrl),
        .thresholds (thresholds)
    );

    akcd_core #(
        .MAX_KEYS    (MAX_KEYS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .thresholds    (thresholds),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_sample     (s_tdata[SAMPLE_BITS-1:0]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .press_valid   (press_valid),
        .press_key     (press_key),
        .release_valid (release_valid),
        .release_key   (release_key)
    );

    assign m_tdata = {release_key, release_valid, press_key, press_valid};

endmodule
`default_nettype wire

>>> hdl/akcd_cfg.sv
`default_nettype none
module akcd_cfg
    import akcd_pkg::*;
#(
    parameter int MAX_KEYS    = MAX_KEYS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int CFG_BITS    = (SAMPLE_BITS > PERIOD_BITS) ? SAMPLE_BITS : PERIOD_BITS
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]              cfg_index,
    input  wire logic [CFG_BITS-1:0]                    cfg_data,
    output akcd_ctrl_t                                  ctrl,
    output logic      [MAX_KEYS-1:0][SAMPLE_BITS-1:0]   thresholds
);

    akcd_ctrl_t ctrl_reg;
    logic [MAX_KEYS-1:0][SAMPLE_BITS-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.key_count    <= RESET_KEY_COUNT;
            ctrl_reg.check_period <= RESET_CHECK_PERIOD;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_KEY_COUNT)
                ctrl_reg.key_count <= cfg_data[KEY_BITS-1:0];
            if (cfg_index == REG_CHECK_PERIOD)
                ctrl_reg.check_period <= cfg_data[PERIOD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_KEYS; i++)
                thr_reg[i] <= SAMPLE_BITS'(RESET_THRESHOLDS[i]);
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < MAX_KEYS; i++)
            begin
                if (cfg_index == CFG_INDEX_BITS'(REG_THRESHOLD_0 + i))
                    thr_reg[i] <= cfg_data[SAMPLE_BITS-1:0];
            end
        end
    end

    assign ctrl       = ctrl_reg;
    assign thresholds = thr_reg;

endmodule
`default_nettype wire

>>> hdl/akcd_core.sv
`default_nettype none
module akcd_core
    import akcd_pkg::*;
#(
    parameter int MAX_KEYS    = MAX_KEYS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire akcd_ctrl_t                             ctrl,
    input  wire logic [MAX_KEYS-1:0][SAMPLE_BITS-1:0]   thresholds,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0]                 in_sample,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        press_valid,
    output key_t                                        press_key,
    output logic                                        release_valid,
    output key_t                                        release_key
);

    localparam logic [KEY_BITS-1:0] MAX_KEYS_K = KEY_BITS'(MAX_KEYS);

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [PERIOD_BITS-1:0] count_reg;
    logic [PERIOD_BITS-1:0] count_next;
    key_t                   held_key_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   press_valid_reg;
    key_t                   press_key_reg;
    logic                   release_valid_reg;
    key_t                   release_key_reg;

    logic                   advance;
    logic                   judged;
    logic                   emit;
    logic [PERIOD_BITS:0]   count_inc;
    logic [KEY_BITS-1:0]    used_keys;
    key_t                   key;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign used_keys = (ctrl.key_count > MAX_KEYS_K) ? MAX_KEYS_K : ctrl.key_count;

    // first threshold in use that the sample lies below
    always_comb
    begin
        key = NO_KEY;
        for (int i = MAX_KEYS - 1; i >= 0; i--)
        begin
            if (KEY_BITS'(i) < used_keys && sample_reg < thresholds[i])
                key = KEY_BITS'(i);
        end
    end

    assign count_inc  = {1'b0, count_reg} + {{PERIOD_BITS{1'b0}}, 1'b1};
    assign judged     = !(count_inc < {1'b0, ctrl.check_period});
    assign count_next = judged ? '0 : count_inc[PERIOD_BITS-1:0];
    assign emit       = judged && (key != held_key_reg);

    assign out_valid_next = advance ? emit : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            held_key_reg  <= NO_KEY;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                count_reg <= count_next;
                if (emit)
                    held_key_reg <= key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            sample_reg <= in_sample;
        if (advance && emit)
        begin
            press_valid_reg   <= (key != NO_KEY);
            press_key_reg     <= (key != NO_KEY) ? key : '0;
            release_valid_reg <= (held_key_reg != NO_KEY);
            release_key_reg   <= (held_key_reg != NO_KEY) ? held_key_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign press_valid   = press_valid_reg;
    assign press_key     = press_key_reg;
    assign release_valid = release_valid_reg;
    assign release_key   = release_key_reg;

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_key_reg <= NO_KEY)
        else $error("held key out of range");

    a_keys_differ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && press_valid_reg && release_valid_reg |->
            press_key_reg != release_key_reg)
        else $error("press and release of the same key");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (press_valid_reg || press_key_reg == '0)
                       && (release_valid_reg || release_key_reg == '0))
        else $error("unused key field not zero");

    a_held_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=>
            held_key_reg == (press_valid_reg ? press_key_reg : NO_KEY))
        else $error("held key does not match the emitted press");

endmodule
`default_nettype wire
